// ----- hdl/mcc_pkg.sv -----
`timescale 1ns / 1ps

package mcc_pkg;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UZ    = 8'd90;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LZ    = 8'd122;
    localparam logic [7:0] CH_D0    = 8'd48;
    localparam logic [7:0] CH_D9    = 8'd57;

    localparam int NUM_LETTERS = 26;
    localparam int NUM_SYMBOLS = 36;

    // job kinds
    localparam logic [1:0] JOB_NONE   = 2'd0;
    localparam logic [1:0] JOB_MARKS  = 2'd1;
    localparam logic [1:0] JOB_SPACES = 2'd2;
    localparam logic [1:0] JOB_CHARS  = 2'd3;

    localparam logic [1:0] SEP_SPACES  = 2'd3;
    localparam logic [2:0] WORD_SPACES = 3'd4;
    localparam logic [2:0] MAX_MARKS   = 3'd5;
    localparam logic [2:0] GAP_MAX     = 3'd7;
    localparam logic [2:0] GAP_WORD    = 3'd4;

    typedef struct packed {
        logic       sep;      // three separator spaces first
        logic [1:0] kind;
        logic [4:0] marks;    // bit k is mark k, 1 = dash
        logic [2:0] len;
        logic       has_a;    // char_a goes before char_b
        logic [7:0] char_a;
        logic [7:0] char_b;
    } job_t;

    typedef struct packed {
        logic [2:0] len;
        logic [4:0] marks;
    } pattern_t;

    // dot-dash pattern of symbol 0..35 (letters, then digits)
    function automatic pattern_t sym_pattern(input logic [5:0] idx);
        pattern_t p;
        unique case (idx)
            6'd0:  p = '{3'd2, 5'b00010};
            6'd1:  p = '{3'd4, 5'b00001};
            6'd2:  p = '{3'd4, 5'b00101};
            6'd3:  p = '{3'd3, 5'b00001};
            6'd4:  p = '{3'd1, 5'b00000};
            6'd5:  p = '{3'd4, 5'b00100};
            6'd6:  p = '{3'd3, 5'b00011};
            6'd7:  p = '{3'd4, 5'b00000};
            6'd8:  p = '{3'd2, 5'b00000};
            6'd9:  p = '{3'd4, 5'b01110};
            6'd10: p = '{3'd3, 5'b00101};
            6'd11: p = '{3'd4, 5'b00010};
            6'd12: p = '{3'd2, 5'b00011};
            6'd13: p = '{3'd2, 5'b00001};
            6'd14: p = '{3'd3, 5'b00111};
            6'd15: p = '{3'd4, 5'b00110};
            6'd16: p = '{3'd4, 5'b01011};
            6'd17: p = '{3'd3, 5'b00010};
            6'd18: p = '{3'd3, 5'b00000};
            6'd19: p = '{3'd1, 5'b00001};
            6'd20: p = '{3'd3, 5'b00100};
            6'd21: p = '{3'd4, 5'b01000};
            6'd22: p = '{3'd3, 5'b00110};
            6'd23: p = '{3'd4, 5'b01001};
            6'd24: p = '{3'd4, 5'b01101};
            6'd25: p = '{3'd4, 5'b00011};
            6'd26: p = '{3'd5, 5'b11111};
            6'd27: p = '{3'd5, 5'b11110};
            6'd28: p = '{3'd5, 5'b11100};
            6'd29: p = '{3'd5, 5'b11000};
            6'd30: p = '{3'd5, 5'b10000};
            6'd31: p = '{3'd5, 5'b00000};
            6'd32: p = '{3'd5, 5'b00001};
            6'd33: p = '{3'd5, 5'b00011};
            6'd34: p = '{3'd5, 5'b00111};
            6'd35: p = '{3'd5, 5'b01111};
            default: p = '{3'd0, 5'b00000};
        endcase
        return p;
    endfunction

endpackage

// ----- hdl/mcc_front.sv -----
`timescale 1ns / 1ps

module mcc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode_we,
    input  logic              mode_wdata,
    input  logic              push,
    input  logic [7:0]        in_char,
    output mcc_pkg::job_t     job
);

    logic       mode_reg,  mode_next;
    logic [4:0] marks_reg, marks_next;
    logic [2:0] len_reg,   len_next;
    logic       inv_reg,   inv_next;
    logic [2:0] gap_reg,   gap_next;
    logic       sep_reg,   sep_next;

    logic       is_alnum;
    logic [5:0] sym_idx;
    logic       tok_hit;
    logic [7:0] tok_char;
    logic       tok_open;
    mcc_pkg::pattern_t enc_pat;

    // text byte to symbol index, lowercase folded to uppercase
    always_comb
    begin
        is_alnum = 1'b1;
        sym_idx  = '0;
        if (in_char >= mcc_pkg::CH_LA && in_char <= mcc_pkg::CH_LZ)
        begin
            sym_idx = 6'(in_char - mcc_pkg::CH_LA);
        end
        else if (in_char >= mcc_pkg::CH_UA && in_char <= mcc_pkg::CH_UZ)
        begin
            sym_idx = 6'(in_char - mcc_pkg::CH_UA);
        end
        else if (in_char >= mcc_pkg::CH_D0 && in_char <= mcc_pkg::CH_D9)
        begin
            sym_idx = 6'(in_char - mcc_pkg::CH_D0 + 8'(mcc_pkg::NUM_LETTERS));
        end
        else
        begin
            is_alnum = 1'b0;
        end
    end

    assign enc_pat = mcc_pkg::sym_pattern(sym_idx);

    // open token against all 36 patterns, first match in symbol order wins
    always_comb
    begin
        mcc_pkg::pattern_t p;
        tok_hit  = 1'b0;
        tok_char = '0;
        for (int s = 0; s < mcc_pkg::NUM_SYMBOLS; s++)
        begin
            p = mcc_pkg::sym_pattern(6'(s));
            if (!tok_hit && p.len == len_reg && p.marks == marks_reg)
            begin
                tok_hit = 1'b1;
                if (s < mcc_pkg::NUM_LETTERS)
                    tok_char = mcc_pkg::CH_UA + 8'(s);
                else
                    tok_char = mcc_pkg::CH_D0 + 8'(s - mcc_pkg::NUM_LETTERS);
            end
        end
        tok_hit = tok_hit && !inv_reg && (len_reg != 3'd0);
    end

    assign tok_open = (len_reg != 3'd0) || inv_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        marks_next = marks_reg;
        len_next   = len_reg;
        inv_next   = inv_reg;
        gap_next   = gap_reg;
        sep_next   = sep_reg;

        job        = '0;
        job.kind   = mcc_pkg::JOB_NONE;

        if (mode_reg == 1'b0)
        begin
            // encode
            if (in_char == mcc_pkg::CH_NL)
            begin
                sep_next    = 1'b0;
                job.kind    = mcc_pkg::JOB_CHARS;
                job.char_b  = mcc_pkg::CH_NL;
            end
            else
            begin
                job.sep = sep_reg;
                if (is_alnum)
                begin
                    job.kind  = mcc_pkg::JOB_MARKS;
                    job.marks = enc_pat.marks;
                    job.len   = enc_pat.len;
                    sep_next  = 1'b1;
                end
                else
                begin
                    job.kind = mcc_pkg::JOB_SPACES;
                    sep_next = 1'b0;
                end
            end
        end
        else
        begin
            // decode
            if (in_char == mcc_pkg::CH_DOT || in_char == mcc_pkg::CH_DASH)
            begin
                gap_next = '0;
                if (len_reg < mcc_pkg::MAX_MARKS)
                begin
                    if (in_char == mcc_pkg::CH_DASH)
                        marks_next = marks_reg | (5'd1 << len_reg);
                    len_next = len_reg + 3'd1;
                end
                else
                begin
                    inv_next = 1'b1;
                end
            end
            else if (in_char == mcc_pkg::CH_SPACE)
            begin
                if (tok_open)
                begin
                    marks_next = '0;
                    len_next   = '0;
                    inv_next   = 1'b0;
                    gap_next   = 3'd1;
                    if (tok_hit)
                    begin
                        job.kind   = mcc_pkg::JOB_CHARS;
                        job.char_b = tok_char;
                    end
                end
                else
                begin
                    if (gap_reg != mcc_pkg::GAP_MAX)
                        gap_next = gap_reg + 3'd1;
                    if (gap_next == mcc_pkg::GAP_WORD)
                    begin
                        job.kind   = mcc_pkg::JOB_CHARS;
                        job.char_b = mcc_pkg::CH_SPACE;
                    end
                end
            end
            else if (in_char == mcc_pkg::CH_NL)
            begin
                marks_next = '0;
                len_next   = '0;
                inv_next   = 1'b0;
                gap_next   = '0;
                job.kind   = mcc_pkg::JOB_CHARS;
                job.has_a  = tok_hit;
                job.char_a = tok_char;
                job.char_b = mcc_pkg::CH_NL;
            end
            else
            begin
                inv_next = 1'b1;
                gap_next = '0;
            end
        end

        if (!push)
        begin
            marks_next = marks_reg;
            len_next   = len_reg;
            inv_next   = inv_reg;
            gap_next   = gap_reg;
            sep_next   = sep_reg;
        end

        // a mode write clears the codec state
        if (mode_we)
        begin
            mode_next  = mode_wdata;
            marks_next = '0;
            len_next   = '0;
            inv_next   = 1'b0;
            gap_next   = '0;
            sep_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            marks_reg <= '0;
            len_reg   <= '0;
            inv_reg   <= 1'b0;
            gap_reg   <= '0;
            sep_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            marks_reg <= marks_next;
            len_reg   <= len_next;
            inv_reg   <= inv_next;
            gap_reg   <= gap_next;
            sep_reg   <= sep_next;
        end
    end

endmodule

// ----- hdl/mcc_queue.sv -----
`timescale 1ns / 1ps

module mcc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcc_pkg::job_t     push_job,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output mcc_pkg::job_t     q_job
);

    mcc_pkg::job_t                 entry_reg [mcc_pkg::QDEPTH];
    logic [mcc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mcc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mcc_pkg::QCNT_W-1:0]    cnt_reg,    cnt_next;

    assign full    = (cnt_reg == mcc_pkg::QCNT_W'(mcc_pkg::QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- hdl/mcc_back.sv -----
`timescale 1ns / 1ps

module mcc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mcc_pkg::job_t     q_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_char,
    output logic              last,
    output logic              none
);

    mcc_pkg::job_t cur_job_reg, cur_job_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [2:0]    pos_reg, pos_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          last_reg, last_next;
    logic          none_reg, none_next;

    logic [1:0]    pre_cnt;
    logic [3:0]    body_cnt;
    logic [3:0]    total;
    logic [2:0]    body_pos;
    logic [4:0]    marks_sh;
    logic [7:0]    byte_val;
    logic          is_last;
    logic          can_load;
    logic          adv;

    // byte at position pos_reg of the current job
    always_comb
    begin
        pre_cnt  = cur_job_reg.sep ? mcc_pkg::SEP_SPACES : 2'd0;
        body_pos = pos_reg - 3'(pre_cnt);
        marks_sh = cur_job_reg.marks >> body_pos;
        body_cnt = 4'd1;
        byte_val = '0;
        unique case (cur_job_reg.kind)
            mcc_pkg::JOB_NONE:
            begin
                body_cnt = 4'd1;
                byte_val = '0;
            end
            mcc_pkg::JOB_MARKS:
            begin
                body_cnt = {1'b0, cur_job_reg.len};
                byte_val = marks_sh[0] ? mcc_pkg::CH_DASH : mcc_pkg::CH_DOT;
            end
            mcc_pkg::JOB_SPACES:
            begin
                body_cnt = {1'b0, mcc_pkg::WORD_SPACES};
                byte_val = mcc_pkg::CH_SPACE;
            end
            mcc_pkg::JOB_CHARS:
            begin
                body_cnt = cur_job_reg.has_a ? 4'd2 : 4'd1;
                byte_val = (cur_job_reg.has_a && body_pos == 3'd0) ?
                           cur_job_reg.char_a : cur_job_reg.char_b;
            end
            default:
            begin
                body_cnt = 4'd1;
                byte_val = '0;
            end
        endcase
        if (pos_reg < 3'(pre_cnt))
            byte_val = mcc_pkg::CH_SPACE;
        total   = body_cnt + 4'(pre_cnt);
        is_last = ({1'b0, pos_reg} == total - 4'd1);
    end

    assign can_load = !out_valid_reg || !out_stall;
    assign adv      = cur_valid_reg && can_load;
    assign pop      = q_valid && (!cur_valid_reg || (adv && is_last));

    always_comb
    begin
        cur_job_next   = cur_job_reg;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        if (pop)
        begin
            cur_job_next   = q_job;
            cur_valid_next = 1'b1;
            pos_next       = '0;
        end
        else if (adv && is_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (adv)
        begin
            pos_next = pos_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        none_next      = none_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_char_next  = byte_val;
            last_next      = is_last;
            none_next      = (cur_job_reg.kind == mcc_pkg::JOB_NONE);
        end
        else if (can_load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg  <= cur_job_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        none_reg     <= none_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign none      = none_reg;

endmodule

// ----- hdl/morse_code_codec_core.sv -----
`timescale 1ns / 1ps

// channel   | handshake                    | payload
// ----------+------------------------------+--------------------------
// input     | in_valid / in_stall          | in_char
// output    | out_valid / out_stall        | out_char, last, none
// mode      | mode_we (write only)         | mode_wdata
//
// one output byte per cycle while out_stall is low; an input byte causes 1
// to 8 result bytes (separator spaces plus marks, spaces or characters),
// emitted by the back end sequencer. a two-entry request queue lets new
// bytes enter while the back end is still emitting. reset clears mode to
// encode and the codec state. in_stall rises only when the request queue is
// full; out_stall holds the output register and in turn backs up the queue.
module morse_code_codec_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_we,
    input  logic       mode_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       last,
    output logic       none
);

    mcc_pkg::job_t front_job;
    mcc_pkg::job_t q_job;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          push;

    // a request is taken whenever the queue has room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // front end: mode register, token and gap tracking, classifies each
    // byte into a job descriptor
    mcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .push       (push),
        .in_char    (in_char),
        .job        (front_job)
    );

    // short queue decoupling classification from emission
    mcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // back end: walks each job one byte a cycle into the output register while out_stall is low
    mcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last),
        .none      (none)
    );

endmodule

// ----- hdl/mcc_checker.sv -----
`timescale 1ns / 1ps

module mcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       last,
    input logic       none
);

    // an empty result is a single byte of zero
    a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none |-> out_char == 8'd0 && last)
        else $error("none result not zero or not last");

    // a real byte is never zero
    a_byte_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !none |-> out_char != 8'd0)
        else $error("zero byte without none");

    // bytes of one request come out back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a result burst");

    // stalled output holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
        else $error("stalled output changed");

endmodule

bind morse_code_codec_core mcc_checker u_mcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last),
    .none      (none)
);
